// File: rtl/lmg_pkg.sv
// Shared types and constants for the MSE/MAE loss and gradient block.
// Used by every module of the block; depends on nothing.
package lmg_pkg;

    // Fixed widths of the result fields and of the running sum.
    localparam int GRAD_W = 18;
    localparam int LOSS_W = 32;
    localparam int SUM_W  = 48;

    // Result stream packing: gradient in the low bits, loss above it, padded to bytes.
    localparam int OUT_LOSS_LSB = GRAD_W;
    localparam int OUT_TDATA_W  = ((GRAD_W + LOSS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 2;
    localparam int TUSER_LOSS_VALID = 0;
    localparam int TUSER_TOO_LONG   = 1;

    // Loss mode register codes.
    localparam logic MODE_MSE = 1'b0;
    localparam logic MODE_MAE = 1'b1;

    // One whole unit in Q10.8, used by the absolute-error gradient.
    localparam logic signed [GRAD_W-1:0] GRAD_POS_ONE = 18'sd256;
    localparam logic signed [GRAD_W-1:0] GRAD_NEG_ONE = -18'sd256;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MAG,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } t_state;

    // Step strobes from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic do_diff;
        logic do_mag;
        logic do_mul;
        logic do_acc;
        logic do_div;
        logic do_done;
    } t_ctrl;

endpackage

// File: rtl/mse_mae_loss_and_gradient.sv
// Top level of the mean squared / mean absolute error loss and gradient block.
// Instantiates lmg_ctrl and lmg_alu and uses constants and types from lmg_pkg.
//
//  Channel   | Direction | Handshake                        | Payload
//  ----------+-----------+----------------------------------+------------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready  | tdata {target, predicted}, tlast
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready  | tdata {loss, gradient}, tuser flags
//  cfg       | in        | i_cfg_valid/o_cfg_ready          | i_cfg_data = loss mode
//
// The difference, magnitude, square, accumulate and divide steps share one adder/subtractor,
// one operation per cycle. An absolute-error item steps through difference, magnitude,
// accumulate and hand-off; a squared-error item adds the bit-serial square of the difference
// magnitude. The item marked last adds a restoring division of the 48-bit sum, one quotient bit per cycle.
// Reset is synchronous and active low; it clears the mode, the batch sum, count and
// overflow flag. A stalled result waits in the output register and holds the sequencer.
module mse_mae_loss_and_gradient #(
    parameter int DATA_WIDTH = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata fields from bit 0 up: predicted, target, zero padding.
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // Result stream.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata fields from bit 0 up: gradient (18), loss (32), zero padding.
    output logic [lmg_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser fields from bit 0 up: loss_valid, too_long.
    output logic [lmg_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);

    // Difference and magnitude width, square width and the shared adder width.
    localparam int MW = DATA_WIDTH + 1;
    localparam int PW = 2 * MW;
    localparam int AW = ((PW > lmg_pkg::SUM_W + 1) ? PW : lmg_pkg::SUM_W + 1) + 1;
    localparam int GW = (DATA_WIDTH + 2 > lmg_pkg::GRAD_W) ? DATA_WIDTH + 2 : lmg_pkg::GRAD_W;
    localparam logic signed [GW-1:0] GRAD_HI = GW'(2 ** (lmg_pkg::GRAD_W - 1) - 1);
    localparam logic signed [GW-1:0] GRAD_LO = GW'(-(2 ** (lmg_pkg::GRAD_W - 1)));

    lmg_pkg::t_ctrl w_ctrl;

    // Configuration register; the port always accepts.
    logic r_mode;

    // Item registers.
    logic [DATA_WIDTH-1:0] r_pred, r_targ;
    logic                  r_last;
    logic [MW-1:0]         r_diff;
    logic [MW-1:0]         r_mag;
    logic [MW-1:0]         r_mplr;
    logic [PW-1:0]         r_prod;

    // Batch state.
    logic [lmg_pkg::SUM_W-1:0] r_sum;
    logic [COUNT_BITS-1:0]     r_count;
    logic                      r_ovf;

    // Division registers: r_quo starts as the dividend and fills with quotient bits.
    logic [lmg_pkg::SUM_W-1:0] r_quo;
    logic [COUNT_BITS-1:0]     r_rem;

    // Output register.
    logic                              r_out_valid;
    logic [lmg_pkg::GRAD_W-1:0]        r_grad;
    logic [lmg_pkg::LOSS_W-1:0]        r_loss;
    logic                              r_loss_valid;
    logic                              r_too_long;

    logic                      w_out_free;
    logic [AW-1:0]             w_a, w_b, w_res;
    lmg_pkg::t_alu_op          w_op;
    logic [COUNT_BITS:0]       w_rem_shift;
    logic [lmg_pkg::SUM_W-1:0] w_sum_next;
    logic signed [GW-1:0]      w_dext, w_twice;
    logic [lmg_pkg::GRAD_W-1:0] w_grad;
    logic [lmg_pkg::LOSS_W-1:0] w_loss;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_rem_shift = {r_rem, r_quo[lmg_pkg::SUM_W-1]};

    lmg_ctrl #(
        .MUL_STEPS (MW),
        .DIV_STEPS (lmg_pkg::SUM_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_mode     (r_mode),
        .i_last     (r_last),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // Operand selection for the shared adder, one operation per sequencer step.
    always_comb begin
        w_a  = '0;
        w_b  = '0;
        w_op = lmg_pkg::ALU_ADD;
        priority if (w_ctrl.do_diff) begin
            w_a  = AW'($signed(r_pred));
            w_b  = AW'($signed(r_targ));
            w_op = lmg_pkg::ALU_SUB;
        end else if (w_ctrl.do_mag) begin
            w_b  = AW'($signed(r_diff));
            w_op = lmg_pkg::ALU_SUB;
        end else if (w_ctrl.do_mul) begin
            // Shift-add square, multiplier bits taken from the top down.
            w_a = AW'({r_prod[PW-2:0], 1'b0});
            w_b = r_mplr[MW-1] ? AW'(r_mag) : '0;
        end else if (w_ctrl.do_acc) begin
            w_a = AW'(r_sum);
            w_b = (r_mode == lmg_pkg::MODE_MSE) ? AW'(r_prod) : AW'(r_mag);
        end else if (w_ctrl.do_div) begin
            w_a  = AW'(w_rem_shift);
            w_b  = AW'(r_count);
            w_op = lmg_pkg::ALU_SUB;
        end else begin
            w_a = '0;
        end
    end

    lmg_alu #(
        .WIDTH (AW)
    ) u_alu (
        .i_a      (w_a),
        .i_b      (w_b),
        .i_op     (w_op),
        .o_result (w_res)
    );

    // The sum saturates instead of wrapping.
    assign w_sum_next = (|w_res[AW-1:lmg_pkg::SUM_W]) ? '1 : w_res[lmg_pkg::SUM_W-1:0];

    // Gradient: twice the difference clamped to the field, or its sign in whole units.
    assign w_dext  = GW'($signed(r_diff));
    assign w_twice = {w_dext[GW-2:0], 1'b0};

    always_comb begin
        if (r_mode == lmg_pkg::MODE_MAE) begin
            if (r_diff == '0) begin
                w_grad = '0;
            end else if (r_diff[MW-1]) begin
                w_grad = lmg_pkg::GRAD_NEG_ONE;
            end else begin
                w_grad = lmg_pkg::GRAD_POS_ONE;
            end
        end else if (w_twice > GRAD_HI) begin
            w_grad = GRAD_HI[lmg_pkg::GRAD_W-1:0];
        end else if (w_twice < GRAD_LO) begin
            w_grad = GRAD_LO[lmg_pkg::GRAD_W-1:0];
        end else begin
            w_grad = w_twice[lmg_pkg::GRAD_W-1:0];
        end
    end

    // The mean is reported only on the last element and clamps at the top of the field.
    always_comb begin
        if (!r_last) begin
            w_loss = '0;
        end else if (|r_quo[lmg_pkg::SUM_W-1:lmg_pkg::LOSS_W]) begin
            w_loss = '1;
        end else begin
            w_loss = r_quo[lmg_pkg::LOSS_W-1:0];
        end
    end

    // Control and batch state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= lmg_pkg::MODE_MSE;
            r_sum       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (w_ctrl.do_acc) begin
                r_sum <= w_sum_next;
                if (r_count != '1) begin
                    r_count <= r_count + COUNT_BITS'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_ctrl.do_done && r_last) begin
                r_sum   <= '0;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (w_ctrl.do_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.in_ready && i_s_axis_tvalid) begin
            r_pred <= i_s_axis_tdata[DATA_WIDTH-1:0];
            r_targ <= i_s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            r_last <= i_s_axis_tlast;
        end
        if (w_ctrl.do_diff) begin
            r_diff <= w_res[MW-1:0];
        end
        if (w_ctrl.do_mag) begin
            r_mag  <= r_diff[MW-1] ? w_res[MW-1:0] : r_diff;
            r_mplr <= r_diff[MW-1] ? w_res[MW-1:0] : r_diff;
            r_prod <= '0;
        end
        if (w_ctrl.do_mul) begin
            r_prod <= w_res[PW-1:0];
            r_mplr <= {r_mplr[MW-2:0], 1'b0};
        end
        if (w_ctrl.do_acc) begin
            r_quo <= w_sum_next;
            r_rem <= '0;
        end
        if (w_ctrl.do_div) begin
            // A negative trial keeps the shifted remainder and gives a zero quotient bit.
            r_rem <= w_res[AW-1] ? w_rem_shift[COUNT_BITS-1:0] : w_res[COUNT_BITS-1:0];
            r_quo <= {r_quo[lmg_pkg::SUM_W-2:0], ~w_res[AW-1]};
        end
        if (w_ctrl.do_done) begin
            r_grad       <= w_grad;
            r_loss       <= w_loss;
            r_loss_valid <= r_last;
            r_too_long   <= r_ovf;
        end
    end

    assign o_s_axis_tready = w_ctrl.in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = lmg_pkg::OUT_TDATA_W'({r_loss, r_grad});
    assign o_m_axis_tuser  = {r_too_long, r_loss_valid};

endmodule

// File: rtl/lmg_alu.sv
// Adder/subtractor shared by the diff, magnitude, square, sum and divide steps.
// Depends on lmg_pkg for the operation code.
module lmg_alu #(
    parameter int WIDTH = 50
) (
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    input  lmg_pkg::t_alu_op     i_op,
    output logic [WIDTH-1:0]     o_result
);

    logic [WIDTH-1:0] w_b;

    always_comb begin
        unique case (i_op)
            lmg_pkg::ALU_SUB: w_b = ~i_b;
            default:          w_b = i_b;
        endcase
    end

    assign o_result = i_a + w_b + WIDTH'(i_op == lmg_pkg::ALU_SUB);

endmodule

// File: rtl/lmg_ctrl.sv
// Sequencer of the loss block: steps one item through difference, magnitude,
// shift-add square, accumulate, restoring divide and result hand-off. Uses lmg_pkg.
module lmg_ctrl #(
    parameter int MUL_STEPS = 17,
    parameter int DIV_STEPS = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_mode,
    input  logic           i_last,
    input  logic           i_out_free,
    output lmg_pkg::t_ctrl o_ctrl
);

    localparam int MAX_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
    localparam int ITER_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    lmg_pkg::t_state r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic w_mul_end, w_div_end;

    assign w_mul_end = (r_iter == ITER_W'(MUL_STEPS - 1));
    assign w_div_end = (r_iter == ITER_W'(DIV_STEPS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmg_pkg::ST_IDLE: if (i_in_valid) n_state = lmg_pkg::ST_DIFF;
            lmg_pkg::ST_DIFF: n_state = lmg_pkg::ST_MAG;
            lmg_pkg::ST_MAG: begin
                n_state = (i_mode == lmg_pkg::MODE_MSE) ? lmg_pkg::ST_MUL : lmg_pkg::ST_ACC;
            end
            lmg_pkg::ST_MUL: if (w_mul_end) n_state = lmg_pkg::ST_ACC;
            lmg_pkg::ST_ACC: n_state = i_last ? lmg_pkg::ST_DIV : lmg_pkg::ST_DONE;
            lmg_pkg::ST_DIV: if (w_div_end) n_state = lmg_pkg::ST_DONE;
            lmg_pkg::ST_DONE: if (i_out_free) n_state = lmg_pkg::ST_IDLE;
            default: n_state = lmg_pkg::ST_IDLE;
        endcase
    end

    // Step counter runs only in the multiply and divide loops.
    always_comb begin
        if (r_state == lmg_pkg::ST_MUL || r_state == lmg_pkg::ST_DIV) begin
            n_iter = r_iter + ITER_W'(1);
        end else begin
            n_iter = '0;
        end
    end

    // Outputs.
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.in_ready = (r_state == lmg_pkg::ST_IDLE);
        o_ctrl.do_diff  = (r_state == lmg_pkg::ST_DIFF);
        o_ctrl.do_mag   = (r_state == lmg_pkg::ST_MAG);
        o_ctrl.do_mul   = (r_state == lmg_pkg::ST_MUL);
        o_ctrl.do_acc   = (r_state == lmg_pkg::ST_ACC);
        o_ctrl.do_div   = (r_state == lmg_pkg::ST_DIV);
        o_ctrl.do_done  = (r_state == lmg_pkg::ST_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmg_pkg::ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

// File: rtl/lmg_checker.sv
// Port-level checker for the loss and gradient block, bound to its top level.
// Depends on lmg_pkg for the result packing constants.
module lmg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [lmg_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [lmg_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // The loss field is zero unless it carries a batch mean.
    a_loss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[lmg_pkg::TUSER_LOSS_VALID] |->
        o_m_axis_tdata[lmg_pkg::OUT_LOSS_LSB+lmg_pkg::LOSS_W-1:lmg_pkg::OUT_LOSS_LSB] == '0)
        else $error("loss not zero outside the last element");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while an item is in progress");

    // Reset leaves the block empty and ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind mse_mae_loss_and_gradient lmg_checker u_lmg_checker (.*);
